// File: src/sptq_pkg.sv
// Package for the sortable priority task queue.
// Holds sizes, operation and status codes, controller states and the
// command/status structs shared by the controller, datapath and top level.
package sptq_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int KEY_W  = 16;
    localparam int HND_W  = 16;
    localparam int ENT_W  = KEY_W + HND_W;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_SORT  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_POP_WR,
        S_SORT_CHK,
        S_SORT_LDI,
        S_SORT_CMP,
        S_SORT_INS,
        S_DONE
    } t_state;

    // Read address sources for the entry memory.
    typedef enum logic [1:0] {
        RD_LAST,
        RD_I,
        RD_IM1,
        RD_JM2
    } t_rd_sel;

    typedef struct packed {
        logic    take_item;
        logic    push;
        logic    pop_wr;
        logic    clear;
        logic    set_status;
        t_status status;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    i_init;
        logic    i_inc;
        logic    ld_key;
        logic    shift;
        logic    insert;
        logic    load_out;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic empty;
        logic full;
        logic i_done;
        logic key_gt;
        logic j_one;
        logic out_free;
    } t_dp_sts;

endpackage

// File: src/sptq_ctrl.sv
// Controller state machine for the sortable priority task queue.
// Depends on sptq_pkg; drives the datapath through t_dp_cmd.
module sptq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    output logic             o_valid,
    input  sptq_pkg::t_dp_sts i_sts,
    output sptq_pkg::t_dp_cmd o_cmd
);
    import sptq_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && !(i_sts.out_free);
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.take_item = 1'b1;
                    n_state         = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.op)
                    OP_PUSH: begin
                        if (i_sts.full) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_FULL;
                        end else begin
                            o_cmd.push = 1'b1;
                        end
                        n_state = S_DONE;
                    end
                    OP_POP: begin
                        if (i_sts.empty) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_EMPTY;
                            n_state          = S_DONE;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_LAST;
                            n_state      = S_POP_WR;
                        end
                    end
                    OP_SORT: begin
                        o_cmd.i_init = 1'b1;
                        n_state      = S_SORT_CHK;
                    end
                    default: begin
                        if (i_sts.empty) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_EMPTY;
                        end else begin
                            o_cmd.clear = 1'b1;
                        end
                        n_state = S_DONE;
                    end
                endcase
            end
            S_POP_WR: begin
                o_cmd.pop_wr = 1'b1;
                n_state      = S_DONE;
            end
            S_SORT_CHK: begin
                if (i_sts.i_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_I;
                    n_state      = S_SORT_LDI;
                end
            end
            S_SORT_LDI: begin
                o_cmd.ld_key = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_IM1;
                n_state      = S_SORT_CMP;
            end
            S_SORT_CMP: begin
                // A larger left neighbor moves up one slot; the walk stops at
                // the first key that is not larger, which keeps the sort stable.
                if (i_sts.key_gt) begin
                    o_cmd.shift = 1'b1;
                    if (i_sts.j_one) begin
                        n_state = S_SORT_INS;
                    end else begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = RD_JM2;
                    end
                end else begin
                    n_state = S_SORT_INS;
                end
            end
            S_SORT_INS: begin
                o_cmd.insert = 1'b1;
                o_cmd.i_inc  = 1'b1;
                n_state      = S_SORT_CHK;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

// File: src/sptq_dp.sv
// Datapath for the sortable priority task queue: entry memory, fill count,
// front-entry copy, sort indexes and the result register. Depends on sptq_pkg.
module sptq_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sptq_pkg::t_dp_cmd           i_cmd,
    output sptq_pkg::t_dp_sts           o_sts,
    input  logic [1:0]                  i_kind,
    input  logic [sptq_pkg::KEY_W-1:0]  i_priority_req,
    input  logic [sptq_pkg::HND_W-1:0]  i_task_id,
    input  logic                        i_out_stall,
    input  logic                        i_out_valid,
    output logic [1:0]                  o_status,
    output logic                        o_front_valid,
    output logic [sptq_pkg::KEY_W-1:0]  o_front_priority,
    output logic [sptq_pkg::HND_W-1:0]  o_front_task,
    output logic [sptq_pkg::CNT_W-1:0]  o_entry_count
);
    import sptq_pkg::*;

    logic [ENT_W-1:0]  mem [DEPTH];
    logic [ENT_W-1:0]  r_rdata;

    t_op               r_op;
    logic [ENT_W-1:0]  r_item;
    t_status           r_status;
    logic [CNT_W-1:0]  r_count;
    logic [ENT_W-1:0]  r_front;
    logic [CNT_W-1:0]  r_i;
    logic [ADDR_W-1:0] r_j;
    logic [ENT_W-1:0]  r_hold;

    logic [1:0]        r_out_status;
    logic              r_out_fvalid;
    logic [KEY_W-1:0]  r_out_prio;
    logic [HND_W-1:0]  r_out_task;
    logic [CNT_W-1:0]  r_out_count;

    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  i_m1;
    logic [ADDR_W-1:0] j_m1;
    logic [ADDR_W-1:0] j_m2;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ENT_W-1:0]  wr_data;
    logic              cnt_zero;

    assign cnt_m1   = r_count - CNT_W'(1);
    assign i_m1     = r_i - CNT_W'(1);
    assign j_m1     = r_j - ADDR_W'(1);
    assign j_m2     = j_m1 - ADDR_W'(1);
    assign cnt_zero = (r_count == '0);

    always_comb begin
        case (i_cmd.rd_sel)
            RD_LAST: rd_addr = cnt_m1[ADDR_W-1:0];
            RD_I:    rd_addr = r_i[ADDR_W-1:0];
            RD_IM1:  rd_addr = i_m1[ADDR_W-1:0];
            RD_JM2:  rd_addr = j_m2;
            default: rd_addr = '0;
        endcase
    end

    // One write port, shared by push, pop, shift and insert.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_j;
        wr_data = r_hold;
        if (i_cmd.push) begin
            wr_en   = 1'b1;
            wr_addr = r_count[ADDR_W-1:0];
            wr_data = r_item;
        end else if (i_cmd.pop_wr) begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = r_rdata;
        end else if (i_cmd.shift) begin
            wr_en   = 1'b1;
            wr_addr = r_j;
            wr_data = r_rdata;
        end else if (i_cmd.insert) begin
            wr_en   = 1'b1;
            wr_addr = r_j;
            wr_data = r_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.push) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.pop_wr) begin
            r_count <= cnt_m1;
        end else if (i_cmd.clear) begin
            r_count <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            r_op     <= t_op'(i_kind);
            r_item   <= {i_priority_req, i_task_id};
            r_status <= ST_OK;
        end else if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        // Slot 0 is mirrored so the result never needs a second read port.
        if ((i_cmd.push && cnt_zero) || i_cmd.pop_wr) begin
            r_front <= wr_data;
        end else if (i_cmd.insert && (r_j == '0)) begin
            r_front <= r_hold;
        end
        if (i_cmd.i_init) begin
            r_i <= CNT_W'(1);
        end else if (i_cmd.i_inc) begin
            r_i <= r_i + CNT_W'(1);
        end
        if (i_cmd.ld_key) begin
            r_hold <= r_rdata;
            r_j    <= r_i[ADDR_W-1:0];
        end else if (i_cmd.shift) begin
            r_j <= j_m1;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_status;
            r_out_fvalid <= !cnt_zero;
            r_out_prio   <= cnt_zero ? '0 : r_front[ENT_W-1:HND_W];
            r_out_task   <= cnt_zero ? '0 : r_front[HND_W-1:0];
            r_out_count  <= r_count;
        end
    end

    assign o_sts.op       = r_op;
    assign o_sts.empty    = cnt_zero;
    assign o_sts.full     = (r_count == CNT_W'(DEPTH));
    assign o_sts.i_done   = (r_i >= r_count);
    assign o_sts.key_gt   = (r_rdata[ENT_W-1:HND_W] > r_hold[ENT_W-1:HND_W]);
    assign o_sts.j_one    = (r_j == ADDR_W'(1));
    assign o_sts.out_free = !i_out_valid || !i_out_stall;

    assign o_status         = r_out_status;
    assign o_front_valid    = r_out_fvalid;
    assign o_front_priority = r_out_prio;
    assign o_front_task     = r_out_task;
    assign o_entry_count    = r_out_count;

endmodule

// File: src/sortable_priority_task_queue.sv
// Top level of the sortable priority task queue.
// Depends on sptq_pkg, sptq_ctrl and sptq_dp.
//
//   Channel   Direction  Handshake           Payload
//   request   in         i_valid / o_stall   i_kind, i_priority_req, i_task_id
//   result    out        o_valid / i_stall   o_status, o_front_valid,
//                                            o_front_priority, o_front_task,
//                                            o_entry_count
//
// One request is worked at a time; o_stall is high from acceptance until its
// result is loaded into the output register. Pop adds one memory read before
// its write; push, clear and rejected requests need no read. Sort runs on the
// single-read entry memory: for each entry past the first it loads the entry
// as the key, walks left moving each larger neighbor up one slot, and inserts
// the key. A new request is taken while an earlier result waits; a held result
// stalls only the final load.
// Reset (synchronous, active low) empties the table; no clearing pass is needed.
module sortable_priority_task_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_kind,
    input  logic [sptq_pkg::KEY_W-1:0]  i_priority_req,
    input  logic [sptq_pkg::HND_W-1:0]  i_task_id,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [1:0]                  o_status,
    output logic                        o_front_valid,
    output logic [sptq_pkg::KEY_W-1:0]  o_front_priority,
    output logic [sptq_pkg::HND_W-1:0]  o_front_task,
    output logic [sptq_pkg::CNT_W-1:0]  o_entry_count
);
    import sptq_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    sptq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    sptq_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_kind           (i_kind),
        .i_priority_req   (i_priority_req),
        .i_task_id        (i_task_id),
        .i_out_stall      (i_stall),
        .i_out_valid      (o_valid),
        .o_status         (o_status),
        .o_front_valid    (o_front_valid),
        .o_front_priority (o_front_priority),
        .o_front_task     (o_front_task),
        .o_entry_count    (o_entry_count)
    );

endmodule
